/* sv/interpolation_search_table_assert.svh */
// Assertion macros for the interpolation search table.
`ifndef INTERPOLATION_SEARCH_TABLE_ASSERT_SVH
`define INTERPOLATION_SEARCH_TABLE_ASSERT_SVH
`ifndef SYNTH
`define IST_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IST_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IST_ASSERT(label, clk, rst, prop, msg)
`define IST_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

/* sv/ist_pkg.sv */
`timescale 1ns / 1ps
package ist_pkg;
  localparam int TableDepth = 1024;
  localparam int IdxW = $clog2(TableDepth);
  localparam int LenW = 11;
  localparam int DataW = 32;
  localparam logic KindWrite = 1'b0;
  localparam logic KindSearch = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_RD_LAST,
    ST_CHECK_ENDS,
    ST_RD_LEFT,
    ST_RD_RIGHT,
    ST_MUL,
    ST_DIV,
    ST_RD_MID,
    ST_CMP_MID,
    ST_DONE
  } state_t;
endpackage

/* sv/ist_ram.sv */
`timescale 1ns / 1ps
module ist_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* sv/interpolation_search_table.sv */
`timescale 1ns / 1ps
// Channel   Direction  Signals
// in        input      in_valid, in_ready, kind, entry_index, value
// out       output     out_valid, out_ready, found, position
// cfg       input      cfg_we, cfg_wdata (table_length)
// A search reads and checks the end entries, then per probe makes 3 table reads, a multiply
// step and a restoring divide of the 43-bit dividend; the divide is skipped, and the probe
// falls on left, when left equals right or their two entries are equal.
// The single RAM read port serialises the reads; the bit-serial divider dominates each probe.
// Reset is synchronous and clears control state and table_length; the table holds no reset
// value. A finished search waits in the done state while an older result is still untaken.
`include "interpolation_search_table_assert.svh"
module interpolation_search_table (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     kind,
  input  logic [9:0]               entry_index,
  input  logic signed [31:0]       value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     found,
  output logic [9:0]               position,
  input  logic                     cfg_we,
  input  logic [10:0]              cfg_wdata
);
  localparam int IW = ist_pkg::IdxW;
  localparam int DW = ist_pkg::DataW;
  localparam int QW = IW + DW + 1;   // width of the product and dividend

  ist_pkg::state_t state, state_next;

  logic [ist_pkg::LenW-1:0] table_length;
  logic signed [DW-1:0]     key;
  logic signed [IW+1:0]     left, right;   // signed so right can go below zero
  logic signed [DW-1:0]     lo;
  logic [QW-1:0]            quo;
  logic [DW:0]              rem;
  logic [DW:0]              dsr;
  logic [5:0]               cnt;
  logic [IW-1:0]            mid;
  logic                     hit;
  logic [IW-1:0]            hit_pos;

  logic                     ram_we;
  logic [IW-1:0]            ram_raddr;
  logic [DW-1:0]            ram_rdata;
  logic signed [DW-1:0]     rd;

  logic [IW:0]              n_eff;
  logic [IW-1:0]            last_idx;
  logic [DW:0]              rem_sh;
  logic [DW:0]              rem_sub;
  logic                     out_free;

  ist_ram #(.Width(DW), .Depth(ist_pkg::TableDepth)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(entry_index),
    .wdata(value),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd = ram_rdata;
  assign n_eff = (table_length > (IW+1)'(ist_pkg::TableDepth)) ?
                 (IW+1)'(ist_pkg::TableDepth) : table_length[IW:0];
  assign last_idx = IW'(n_eff - 1'b1);
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ist_pkg::ST_IDLE);
  assign ram_we = in_valid && in_ready && (kind == ist_pkg::KindWrite);
  assign rem_sh = {rem[DW-1:0], quo[QW-1]};
  assign rem_sub = rem_sh - dsr;

  always_comb begin
    state_next = state;
    ram_raddr = '0;
    unique case (state)
      ist_pkg::ST_IDLE: begin
        if (in_valid && in_ready && kind == ist_pkg::KindSearch) begin
          state_next = ist_pkg::ST_RD_FIRST;
        end
      end
      ist_pkg::ST_RD_FIRST: begin
        ram_raddr = '0;
        state_next = (n_eff == '0) ? ist_pkg::ST_DONE : ist_pkg::ST_RD_LAST;
      end
      ist_pkg::ST_RD_LAST: begin
        ram_raddr = last_idx;
        state_next = ist_pkg::ST_CHECK_ENDS;
      end
      ist_pkg::ST_CHECK_ENDS: state_next = ist_pkg::ST_RD_LEFT;
      ist_pkg::ST_RD_LEFT: begin
        ram_raddr = left[IW-1:0];
        state_next = (left > right) ? ist_pkg::ST_DONE : ist_pkg::ST_RD_RIGHT;
      end
      ist_pkg::ST_RD_RIGHT: begin
        ram_raddr = right[IW-1:0];
        state_next = ist_pkg::ST_MUL;
      end
      ist_pkg::ST_MUL: begin
        if (key < lo || key > rd) begin
          state_next = ist_pkg::ST_DONE;
        end else if (left == right || rd == lo) begin
          state_next = ist_pkg::ST_RD_MID;
        end else begin
          state_next = ist_pkg::ST_DIV;
        end
      end
      ist_pkg::ST_DIV: begin
        if (cnt == 6'(QW - 1)) state_next = ist_pkg::ST_RD_MID;
      end
      ist_pkg::ST_RD_MID: begin
        ram_raddr = mid;
        state_next = ist_pkg::ST_CMP_MID;
      end
      ist_pkg::ST_CMP_MID: begin
        state_next = (rd == key) ? ist_pkg::ST_DONE : ist_pkg::ST_RD_LEFT;
      end
      ist_pkg::ST_DONE: state_next = out_free ? ist_pkg::ST_IDLE : ist_pkg::ST_DONE;
      default: state_next = ist_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ist_pkg::ST_IDLE;
      table_length <= '0;
      out_valid <= 1'b0;
      found <= 1'b0;
      position <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) table_length <= cfg_wdata;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == ist_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
        found <= hit;
        position <= hit_pos;
      end
    end
  end

  // Datapath; hit and hit_pos are set on the way into the done state.
  always_ff @(posedge clk) begin
    unique case (state)
      ist_pkg::ST_IDLE: begin
        key <= value;
        hit <= 1'b0;
        hit_pos <= '0;
      end
      ist_pkg::ST_RD_FIRST: begin
        left <= '0;
        right <= (IW+2)'(last_idx);
      end
      ist_pkg::ST_RD_LAST: lo <= rd;  // first entry arrives now
      ist_pkg::ST_CHECK_ENDS: begin
        // rd holds the last entry; a key outside the ends empties the range
        if (key < lo || key > rd) begin
          right <= -(IW+2)'(1);
        end
      end
      ist_pkg::ST_RD_LEFT: ;
      ist_pkg::ST_RD_RIGHT: lo <= rd;
      ist_pkg::ST_MUL: begin
        mid <= left[IW-1:0];
        quo <= QW'(unsigned'(DW'(right - left)) * unsigned'(DW'(key - lo)));
        dsr <= (DW+1)'(rd) - (DW+1)'(lo);
        rem <= '0;
        cnt <= '0;
      end
      ist_pkg::ST_DIV: begin
        if (rem_sub[DW]) begin
          rem <= rem_sh;
          quo <= {quo[QW-2:0], 1'b0};
        end else begin
          rem <= rem_sub;
          quo <= {quo[QW-2:0], 1'b1};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'(QW - 1)) begin
          mid <= IW'(left[IW-1:0] + (rem_sub[DW] ? quo[IW-2:0] << 1 :
                 (quo[IW-2:0] << 1) | IW'(1)));
        end
      end
      ist_pkg::ST_RD_MID: ;
      ist_pkg::ST_CMP_MID: begin
        if (rd == key) begin
          hit <= 1'b1;
          hit_pos <= mid;
        end else if (rd < key) begin
          left <= (IW+2)'(mid) + (IW+2)'(1);
        end else begin
          right <= (IW+2)'(mid) - (IW+2)'(1);
        end
      end
      default: ;
    endcase
  end

  `IST_ASSERT(a_no_accept_busy, clk, rst, (state != ist_pkg::ST_IDLE) |-> !in_ready,
              "input accepted while a search is running")
  `IST_ASSERT(a_pos_zero, clk, rst, (out_valid && !found) |-> (position == '0),
              "position not zero on a miss")
  `IST_ASSERT(a_hold_result, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(found) && $stable(position)),
              "pending result changed before it was taken")
  `IST_ASSERT_RST(a_rst_idle, clk, $past(rst) |-> (state == ist_pkg::ST_IDLE && !out_valid),
                  "control state not cleared by reset")
endmodule
